>>> rtl/binary_morphology_3x3_assert.svh
// Assertion macros shared by the morphology block
`ifndef BINARY_MORPHOLOGY_3X3_ASSERT_SVH
`define BINARY_MORPHOLOGY_3X3_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BM3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binary_morphology_3x3: assertion failed");

// next-cycle implication, disabled in reset
`define BM3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("binary_morphology_3x3: assertion failed");

`endif

>>> rtl/bm3_pkg.sv
package bm3_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_ERODE  = 2'd0;
  localparam logic [1:0] MODE_DILATE = 2'd1;
  localparam logic [1:0] MODE_OPEN   = 2'd2;
  localparam logic [1:0] MODE_CLOSE  = 2'd3;

  localparam logic [7:0] PIXEL_MAX = 8'd255;
  localparam logic [7:0] PIXEL_MIN = 8'd0;

  // [row][col], row 0 oldest line, col 2 newest column
  typedef logic [2:0][2:0][7:0] win_t;

  // word passed between stages
  typedef struct packed {
    logic       flush;
    logic       last;
    logic [7:0] pixel;
  } tok_t;

  function automatic logic [7:0] morph(input win_t w, input logic erode);
    logic any_min;
    logic any_max;
    any_min = 1'b0;
    any_max = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        any_min = any_min | (w[r][c] == PIXEL_MIN);
        any_max = any_max | (w[r][c] == PIXEL_MAX);
      end
    end
    if (erode) begin
      morph = any_min ? PIXEL_MIN : PIXEL_MAX;
    end else begin
      morph = any_max ? PIXEL_MAX : PIXEL_MIN;
    end
  endfunction

endpackage

>>> rtl/bm3_ram.sv
module bm3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bm3_stage.sv
module bm3_stage #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                erode_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_i,
  input  logic [$clog2(MAX_HEIGHT+2)-1:0]     height_i,
  input  logic                                clear_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bm3_pkg::tok_t                       in_tok_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bm3_pkg::tok_t                       out_tok_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  // position of the next step
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // input register
  logic          p_valid_q;
  logic          p_step_q;
  logic [7:0]    p_pix_q;
  logic [AW-1:0] p_col_q;
  logic          p_emit_q, p_int_q, p_fin_q;
  logic          fwd_q;
  logic [15:0]   fwd_data_q;

  // result register
  logic          r_valid_q;
  bm3_pkg::tok_t r_tok_q;

  bm3_pkg::win_t win_q, win_d;

  logic          draining, in_step, accept, p_adv;
  logic          emit, interior, fin;
  logic [CW-1:0] col_inc;
  logic          ram_we;
  logic [15:0]   ram_wdata, ram_rdata, line_rd;
  logic [7:0]    res_pix;

  assign draining = row_q >= height_i;
  assign in_step  = draining || !in_tok_i.flush;
  assign p_adv    = p_valid_q && (!r_valid_q || out_ready_i);
  assign in_ready_o = !p_valid_q || p_adv;
  assign accept   = in_valid_i && in_ready_o;

  assign emit     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
  assign interior = (col_q >= AW'(2)) && (row_q >= RW'(2)) &&
                    (row_q <= RW'(height_i - RW'(1)));
  assign fin      = (row_q >= RW'(height_i + RW'(1))) && (col_q == '0);
  assign col_inc  = CW'(col_q) + CW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept && in_step) begin
      if (fin) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc == width_i) begin
        col_d = '0;
        row_d = RW'(row_q + RW'(1));
      end else begin
        col_d = AW'(col_inc);
      end
    end
  end

  // line word: [15:8] two rows back, [7:0] previous row
  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_we    = p_adv && p_step_q;
  assign ram_wdata = {line_rd[7:0], p_pix_q};

  bm3_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(p_col_q),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = line_rd[15:8];
    win_d[1][2] = line_rd[7:0];
    win_d[2][2] = p_pix_q;
  end

  // borders pass the centre through
  assign res_pix = p_int_q ? bm3_pkg::morph(win_d, erode_i) : win_d[1][1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      win_q     <= '0;
      fwd_q     <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (p_adv) begin
        p_valid_q <= 1'b0;
      end
      if (accept) begin
        // write of the word ahead lands on the address read now
        fwd_q <= ram_we && (p_col_q == col_q);
      end
      if (ram_we) begin
        win_q <= win_d;
      end
      if (p_adv) begin
        r_valid_q <= p_step_q ? p_emit_q : 1'b1;
      end else if (out_ready_i) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_step_q   <= in_step;
      p_pix_q    <= draining ? bm3_pkg::PIXEL_MIN : in_tok_i.pixel;
      p_col_q    <= col_q;
      p_emit_q   <= emit;
      p_int_q    <= interior;
      p_fin_q    <= fin;
      fwd_data_q <= ram_wdata;
    end
    if (p_adv) begin
      r_tok_q.flush <= !p_step_q;
      r_tok_q.last  <= p_fin_q;
      r_tok_q.pixel <= res_pix;
    end
  end

  assign out_valid_o = r_valid_q;
  assign out_tok_o   = r_tok_q;

endmodule

>>> rtl/binary_morphology_3x3.sv
// 3x3 binary morphology (erosion, dilation, opening, closing) on a raster
// pixel stream. One word per clock is taken and given in steady state; each
// stage is an input register, one line-store read and a result register,
// so back-pressure on the output stalls the input combinationally. A stage
// delays the stream by W+1 words: after the last pixel of a frame send W+1
// flush words (tuser set) for erosion or dilation, 2*(W+1) for opening or
// closing, to drain it; the final output word carries tlast. Border rows
// and columns pass the stage input through. Mode, width and height writes
// restart the frame. Register writes must only happen while the block is
// empty. Line stores are not cleared after reset and need no clearing pass.
`include "binary_morphology_3x3_assert.svh"

module binary_morphology_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bm3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // pixel_in
  input  logic [0:0]                       s_axis_tuser_i,  // flush
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,  // pixel_out
  output logic                             m_axis_tlast_o   // frame_last
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  logic [1:0]                     mode_q;
  logic [bm3_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [CW-1:0]                  w_eff;
  logic [RW-1:0]                  h_eff;
  logic                           cfg_clear, erode1, cascade;

  bm3_pkg::tok_t in_tok, s1_tok, s2_tok;
  logic s1_out_valid, s1_out_ready, s2_in_valid, s2_in_ready;
  logic s2_out_valid, s2_out_ready;

  assign cfg_clear = cfg_we_i && ((cfg_idx_i == bm3_pkg::REG_MODE) ||
                                  (cfg_idx_i == bm3_pkg::REG_WIDTH) ||
                                  (cfg_idx_i == bm3_pkg::REG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bm3_pkg::MODE_ERODE;
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bm3_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
        bm3_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        bm3_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < 11'd3) begin
      w_eff = CW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q < 11'd3) begin
      h_eff = RW'(3);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  assign erode1  = (mode_q == bm3_pkg::MODE_ERODE) || (mode_q == bm3_pkg::MODE_OPEN);
  assign cascade = (mode_q == bm3_pkg::MODE_OPEN) || (mode_q == bm3_pkg::MODE_CLOSE);

  assign in_tok.flush = s_axis_tuser_i[0];
  assign in_tok.last  = 1'b0;
  assign in_tok.pixel = s_axis_tdata_i;

  bm3_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_stage1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .erode_i    (erode1),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .clear_i    (cfg_clear),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_tok_i   (in_tok),
    .out_valid_o(s1_out_valid),
    .out_ready_i(s1_out_ready),
    .out_tok_o  (s1_tok)
  );

  // flush words leaving the last stage are dropped
  assign s1_out_ready = cascade ? s2_in_ready : (s1_tok.flush || m_axis_tready_i);
  assign s2_in_valid  = cascade && s1_out_valid;
  assign s2_out_ready = s2_tok.flush || m_axis_tready_i;

  bm3_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_stage2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .erode_i    (!erode1),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .clear_i    (cfg_clear),
    .in_valid_i (s2_in_valid),
    .in_ready_o (s2_in_ready),
    .in_tok_i   (s1_tok),
    .out_valid_o(s2_out_valid),
    .out_ready_i(s2_out_ready),
    .out_tok_o  (s2_tok)
  );

  assign m_axis_tvalid_o = cascade ? (s2_out_valid && !s2_tok.flush)
                                   : (s1_out_valid && !s1_tok.flush);
  assign m_axis_tdata_o  = cascade ? s2_tok.pixel : s1_tok.pixel;
  assign m_axis_tlast_o  = cascade ? s2_tok.last : s1_tok.last;

  // an open output never holds back the input
  `BM3_ASSERT_NOW(a_ready_flow, clk_i, rst_ni, m_axis_tready_i, s_axis_tready_o)
  // input stalls only behind a blocked first-stage result
  `BM3_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready_o,
                  s1_out_valid && !s1_out_ready)

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 1024;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam logic [bm3_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unused index

  typedef enum logic [1:0] {TK_NONE, TK_PIXEL, TK_FLUSH} tok_kind_e;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } out_word_t;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           cfg_we   = 1'b0;
  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_valid  = 1'b0;
  logic                           s_ready;
  logic [7:0]                     s_data   = '0;
  logic [0:0]                     s_user   = '0;
  logic                           m_valid;
  logic                           m_ready  = 1'b0;
  logic [7:0]                     m_data;
  logic                           m_last;

  // morphology predictor: one set of state per stage
  bit [7:0]    line_mem [2][2*MAX_W];
  bit [7:0]    win_px   [2][3][3];
  int unsigned row_pos  [2];
  int unsigned col_pos  [2];
  logic [1:0]  cur_mode;
  logic [10:0] cur_width;
  logic [10:0] cur_height;

  out_word_t   expected_px [$];
  out_word_t   exp_w;
  int unsigned px_predicted = 0;
  int unsigned mismatch_cnt = 0;
  bit          idle_on      = 1'b1;
  int unsigned hold_req     = 0;
  int unsigned stall_left   = 0;

  binary_morphology_3x3 DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // pixel_in
    .s_axis_tuser_i  (s_user),   // flush
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // pixel_out
    .m_axis_tlast_o  (m_last)    // frame_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned max_v);
    if (v < 11'd3) return 3;
    if (32'(v) > max_v) return max_v;
    return 32'(v);
  endfunction

  function automatic int unsigned cur_w();
    return clamp_dim(cur_width, MAX_W);
  endfunction

  function automatic int unsigned cur_h();
    return clamp_dim(cur_height, MAX_H);
  endfunction

  function automatic bit is_cascade();
    return (cur_mode == bm3_pkg::MODE_OPEN) || (cur_mode == bm3_pkg::MODE_CLOSE);
  endfunction

  function automatic int unsigned drain_len();
    return (is_cascade() ? 2 : 1) * (cur_w() + 1);
  endfunction

  function automatic void reset_model();
    foreach (line_mem[s, i]) line_mem[s][i] = '0;
    foreach (win_px[s, r, c]) win_px[s][r][c] = '0;
    row_pos    = '{0, 0};
    col_pos    = '{0, 0};
    cur_mode   = bm3_pkg::MODE_ERODE;
    cur_width  = 11'd1024;
    cur_height = 11'd1024;
  endfunction

  function automatic void apply_reg(input logic [bm3_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bm3_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bm3_pkg::REG_MODE:   cur_mode = val[1:0];
      bm3_pkg::REG_WIDTH:  cur_width = val;
      bm3_pkg::REG_HEIGHT: cur_height = val;
      default:             return;
    endcase
    // any real register write restarts both stages
    row_pos = '{0, 0};
    col_pos = '{0, 0};
  endfunction

  function automatic bit [7:0] window_result(input int stg, input bit erode);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (erode && win_px[stg][r][c] == bm3_pkg::PIXEL_MIN) return bm3_pkg::PIXEL_MIN;
        if (!erode && win_px[stg][r][c] == bm3_pkg::PIXEL_MAX) return bm3_pkg::PIXEL_MAX;
      end
    end
    return erode ? bm3_pkg::PIXEL_MAX : bm3_pkg::PIXEL_MIN;
  endfunction

  function automatic tok_kind_e stage_advance(input int stg, input tok_kind_e tk,
                                              input bit [7:0] pix, input bit erode,
                                              output bit [7:0] val, output bit fin_o);
    int unsigned w, h, c, r;
    bit [7:0]    v;
    bit          emit, interior, fin;
    val   = '0;
    fin_o = 1'b0;
    if (tk == TK_NONE) return TK_NONE;
    w = cur_w();
    h = cur_h();
    if (row_pos[stg] < h) begin
      if (tk == TK_FLUSH) return TK_FLUSH;
      v = pix;
    end else begin
      v = bm3_pkg::PIXEL_MIN;  // draining: incoming value is dropped
    end
    c = col_pos[stg];
    r = row_pos[stg];
    if (c >= w) c = w - 1;
    for (int i = 0; i < 3; i++) begin
      win_px[stg][i][0] = win_px[stg][i][1];
      win_px[stg][i][1] = win_px[stg][i][2];
    end
    win_px[stg][0][2] = line_mem[stg][MAX_W + c];
    win_px[stg][1][2] = line_mem[stg][c];
    win_px[stg][2][2] = v;
    line_mem[stg][MAX_W + c] = line_mem[stg][c];
    line_mem[stg][c] = v;
    emit     = (r >= 2) || (r == 1 && c >= 1);
    interior = (c >= 2) && (r >= 2) && (r <= h - 1);
    fin      = (r >= h + 1) && (c == 0);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (fin) begin
      r = 0;
      c = 0;
    end
    row_pos[stg] = r;
    col_pos[stg] = c;
    if (!emit) return TK_NONE;
    val   = interior ? window_result(stg, erode) : win_px[stg][1][1];
    fin_o = fin;
    return TK_PIXEL;
  endfunction

  function automatic void predict_morph(input bit [7:0] pix, input bit flush);
    tok_kind_e t1, t2;
    bit [7:0]  v1, v2;
    bit        l1, l2, erode1;
    erode1 = (cur_mode == bm3_pkg::MODE_ERODE) || (cur_mode == bm3_pkg::MODE_OPEN);
    t1 = stage_advance(0, flush ? TK_FLUSH : TK_PIXEL, pix, erode1, v1, l1);
    if (!is_cascade()) begin
      if (t1 == TK_PIXEL) begin
        expected_px.push_back('{pixel: v1, last: l1});
        px_predicted++;
      end
    end else begin
      t2 = stage_advance(1, t1, v1, !erode1, v2, l2);
      if (t2 == TK_PIXEL) begin
        expected_px.push_back('{pixel: v2, last: l2});
        px_predicted++;
      end
    end
  endfunction

  function automatic logic [7:0] rand_pixel(input int unsigned pct_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'($urandom_range(0, 255));
    if (r < 5 + pct_max) return bm3_pkg::PIXEL_MAX;
    return bm3_pkg::PIXEL_MIN;
  endfunction

  // receiver: random hold-offs, plus a long one on request
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_ready <= 1'b0;
    end else if (hold_req != 0) begin
      stall_left = hold_req - 1;
      hold_req   = 0;
      m_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (expected_px.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: word with none pending: pixel=%0d last=%0b", $time, m_data, m_last);
      end else begin
        exp_w = expected_px.pop_front();
        if (m_data !== exp_w.pixel || m_last !== exp_w.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: pixel exp %0d got %0d, last exp %0b got %0b", $time,
                     exp_w.pixel, m_data, exp_w.last, m_last);
        end
      end
    end
  end

  // called and returns at a falling edge; tvalid is left high for the caller
  task automatic send_word(input logic [7:0] pix, input logic flush);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= pix;
    s_user  <= flush;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_morph(pix, flush);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bm3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bm3_pkg::CFG_DATA_W-1:0] val);
    cfg_idx  <= idx;
    cfg_data <= val;
    cfg_we   <= 1'b1;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [1:0] md, input logic [10:0] w, input logic [10:0] h);
    // upper bits of the mode word are don't-care
    write_reg(bm3_pkg::REG_MODE, {9'($urandom_range(0, 511)), md});
    write_reg(bm3_pkg::REG_WIDTH, w);
    write_reg(bm3_pkg::REG_HEIGHT, h);
  endtask

  task automatic send_frame(input int unsigned pct_max, input bit noisy);
    int unsigned n_px, n_drain, n_extra;
    n_px    = cur_w() * cur_h();
    n_drain = drain_len();
    n_extra = noisy ? $urandom_range(0, 3) : 0;
    for (int i = 0; i < n_px; i++) begin
      if (noisy && $urandom_range(0, 5) == 0)
        send_word(8'($urandom_range(0, 255)), 1'b1);
      send_word(rand_pixel(pct_max), 1'b0);
    end
    for (int i = 0; i < n_drain; i++) begin
      if (noisy && $urandom_range(0, 2) == 0)
        send_word(8'($urandom_range(0, 255)), 1'b0);
      else
        send_word(8'($urandom_range(0, 255)), 1'b1);
    end
    for (int i = 0; i < n_extra; i++)
      send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed_erosion();
    set_frame(bm3_pkg::MODE_ERODE, 11'd0, 11'd2);  // both clamp to 3
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(8'd128, 1'b0);
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(bm3_pkg::PIXEL_MIN, 1'b1);  // flush mid-frame, dropped
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(8'd1, 1'b0);
    wait_idle();
    write_reg(REG_SPARE, '1);    // must not restart the frame
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    // drain: flushes and pixels both step it
    send_word(8'hA5, 1'b1);
    send_word(bm3_pkg::PIXEL_MIN, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(bm3_pkg::PIXEL_MAX, 1'b0);
    send_word(bm3_pkg::PIXEL_MAX, 1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned frame_no, kind, pct, k, goal;
    logic [1:0]  md;
    logic [10:0] w, h;
    frame_no = 0;
    goal     = px_predicted + 200;
    while (px_predicted < goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (frame_no < 4 || $urandom_range(0, 2) != 0) begin
        wait_idle();
        md = (frame_no < 4) ? frame_no[1:0] : 2'($urandom_range(0, 3));
        w  = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8));
        h  = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 6));
        set_frame(md, w, h);
      end
      pct  = $urandom_range(10, 95);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_frame(pct, 1'b0);
      end else if (kind == 7) begin
        send_frame(pct, 1'b1);
      end else begin
        if (kind == 8) begin
          // cut the frame short, then restart it
          k = $urandom_range(1, cur_w() * cur_h() - 1);
          for (int i = 0; i < k; i++) send_word(rand_pixel(pct), 1'b0);
        end else begin
          k = $urandom_range(5, 20);
          for (int i = 0; i < k; i++)
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        wait_idle();
        write_reg(bm3_pkg::REG_MODE, {9'($urandom_range(0, 511)), cur_mode});
      end
      frame_no++;
    end
  endtask

  task automatic test_output_stall();
    wait_idle();
    idle_on = 1'b0;
    set_frame(bm3_pkg::MODE_OPEN, 11'd8, 11'd6);
    hold_req = 300;
    send_frame(60, 1'b0);
    wait_idle();
  endtask

  task automatic test_tail_frame();
    wait_idle();
    idle_on = 1'b0;
    // height below the minimum clamps to 3
    set_frame(bm3_pkg::MODE_CLOSE, 11'd9, 11'd1);
    send_frame(50, 1'b0);
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_erosion();
    test_random_frames();
    test_output_stall();
    test_tail_frame();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bm3_pkg.sv
rtl/bm3_ram.sv
rtl/bm3_stage.sv
rtl/binary_morphology_3x3.sv
sim/tb.sv
